// File: hw/rtl/kaf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_pkg: shared types and constants for the angle Kalman filter
// Register indexes, reset values, sequencer state encoding.
// ----------------------------------------------------------------------------
package kaf_pkg;

  localparam logic [2:0] REG_ANGLE_Q = 3'd0;
  localparam logic [2:0] REG_BIAS_Q  = 3'd1;
  localparam logic [2:0] REG_MEAS_R  = 3'd2;
  localparam logic [2:0] REG_START_A = 3'd3;
  localparam logic [2:0] REG_START_B = 3'd4;

  localparam logic [31:0] ANGLE_Q_RESET = 32'd4294967;
  localparam logic [31:0] BIAS_Q_RESET  = 32'd12884902;
  localparam logic [31:0] MEAS_R_RESET  = 32'd128849019;

  localparam int QUOT_BITS = 64;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRED = 6'b000010,
    ST_COV  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_CORR = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  // Saturate a 66-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (x > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (x < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = x[31:0];
    end
  endfunction

endpackage

// File: hw/rtl/kaf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_div: restoring divider, one quotient bit per cycle
// Unsigned 64 / 34 bit quotient, magnitudes only.
// ----------------------------------------------------------------------------
module kaf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [33:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [6:0]  count;
  logic [34:0] rem;
  logic [35:0] trial;

  assign trial = {rem, quotient[63]} - {2'b00, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 7'(kaf_pkg::QUOT_BITS);
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      if (trial[35]) begin
        rem      <= {rem[33:0], quotient[63]};
        quotient <= {quotient[62:0], 1'b0};
      end else begin
        rem      <= trial[34:0];
        quotient <= {quotient[62:0], 1'b1};
      end
      count <= count - 7'd1;
      if (count == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/kalman_angle_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_filter_top: two-state angle / gyro bias Kalman filter
// Fuses an absolute angle with a gyro rate; fixed point, saturating.
// ----------------------------------------------------------------------------
// Usage:
//   Input request: measured_angle, gyro_rate, time_step with in_valid; the
//   block takes it when in_valid is high and in_stall is low. in_stall stays
//   high from acceptance until the result has been handed off, and also while
//   a configuration write is offered, so the write goes first.
//   Output request: filtered_angle, corrected_rate, bias_out with out_valid,
//   taken when out_stall is low. A stalled result holds; the next input is
//   refused until it leaves.
//   Configuration: cfg_valid / cfg_ready with cfg_index and cfg_data, only
//   while idle. Indexes 0..2 set noises, 3 loads the angle, 4 loads the bias
//   (both clear the covariance). Other indexes are dropped.
//   Sequence: after acceptance, 8 prediction steps run on the shared 34x34
//   multiplier, then the innovation variance is checked. If it is positive,
//   two 64-step divider runs compute the gains; then 7 correction steps run
//   and out_valid rises. With a non-positive variance the divider is
//   skipped and the gains are zero.
//   Reset: state, covariance and registers return to their reset values.
// ----------------------------------------------------------------------------
module kalman_angle_filter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] gyro_rate,
  input  logic [16:0]        time_step,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] filtered_angle,
  output logic signed [31:0] corrected_rate,
  output logic signed [31:0] bias_out,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  kaf_pkg::state_t state;
  logic [3:0] step;

  logic [31:0] q_angle, q_bias, r_meas;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, rate, k0, k1;
  logic signed [32:0] innov;
  logic [16:0] dt;

  // shared multiplier operands and registered product
  logic signed [33:0] ma, mb;
  logic signed [67:0] prod;
  logic signed [65:0] acc;
  logic [5:0] rsh;
  logic signed [65:0] rounded;

  logic        div_start, div_busy;
  logic [63:0] div_num, div_q;
  logic [33:0] div_den;
  logic signed [34:0] s_val;
  logic        num_neg;
  logic        div_sel;

  // hold input requests off while a configuration write is offered
  assign in_stall  = (state != kaf_pkg::ST_IDLE) || cfg_valid;
  assign cfg_ready = (state == kaf_pkg::ST_IDLE);
  assign out_valid = (state == kaf_pkg::ST_DONE);
  assign filtered_angle = ang;
  assign bias_out = bias;

  // round-half-up then floor by rsh bits (16, 20 or 28)
  always_comb begin
    rounded = ($signed(prod[65:0]) + (66'sd1 <<< (rsh - 6'd1))) >>> rsh;
  end

  kaf_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(div_num), .divisor(div_den),
    .busy(div_busy), .quotient(div_q)
  );

  function automatic logic signed [31:0] gain_of(input logic [63:0] q,
                                                  input logic neg);
    logic signed [65:0] v;
    v = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    gain_of = kaf_pkg::sat32(v);
  endfunction

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  always_comb begin
    ma = '0;
    mb = '0;
    rsh = 6'd16;
    case (step)
      4'd0: begin ma = 34'(signed'({1'b0, dt})); mb = 34'(rate); end
      4'd2: begin ma = 34'(signed'({1'b0, dt})); mb = 34'(p11); end
      4'd4: begin ma = 34'(signed'({1'b0, dt})); mb = 34'(kaf_pkg::sat32(acc)); end
      4'd6: begin ma = 34'(signed'({1'b0, dt})); mb = signed'({2'b00, q_bias});
        rsh = 6'd20; end
      4'd8: begin ma = 34'(k0); mb = 34'(innov); rsh = 6'd28; end
      4'd9: begin ma = 34'(k1); mb = 34'(innov); rsh = 6'd28; end
      4'd10: begin ma = 34'(k0); mb = 34'(p00); rsh = 6'd28; end
      4'd11: begin ma = 34'(k1); mb = 34'(p00); rsh = 6'd28; end
      4'd12: begin ma = 34'(k0); mb = 34'(p01); rsh = 6'd28; end
      4'd13: begin ma = 34'(k1); mb = 34'(p01); rsh = 6'd28; end
      default: begin ma = '0; mb = '0; end
    endcase
    // rounding uses shift of the step whose product is now in prod
    case (step)
      4'd7: rsh = 6'd20;
      4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14: rsh = 6'd28;
      default: rsh = 6'd16;
    endcase
  end

  // divisor and numerator magnitude for the current gain
  always_comb begin
    s_val   = 35'(p00) + 35'(signed'({3'b000, (r_meas + 32'd8) >> 4}))
              + 35'(signed'({34'd0, (r_meas > 32'hfffffff7)})) * 35'sd268435456;
    num_neg = div_sel ? p10[31] : p00[31];
    div_den = s_val[33:0];
    div_num = div_sel ? 64'({(p10[31] ? -33'(p10) : 33'(p10)), 28'd0})
                      : 64'({(p00[31] ? -33'(p00) : 33'(p00)), 28'd0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= kaf_pkg::ST_IDLE;
      step    <= '0;
      q_angle <= kaf_pkg::ANGLE_Q_RESET;
      q_bias  <= kaf_pkg::BIAS_Q_RESET;
      r_meas  <= kaf_pkg::MEAS_R_RESET;
      ang <= '0; bias <= '0;
      p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
      div_start <= 1'b0;
      div_sel   <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        kaf_pkg::ST_IDLE: begin
          if (cfg_valid) begin
            case (cfg_index)
              kaf_pkg::REG_ANGLE_Q: q_angle <= cfg_data;
              kaf_pkg::REG_BIAS_Q:  q_bias  <= cfg_data;
              kaf_pkg::REG_MEAS_R:  r_meas  <= cfg_data;
              kaf_pkg::REG_START_A: begin
                ang <= cfg_data; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
              end
              kaf_pkg::REG_START_B: begin
                bias <= cfg_data; p00 <= '0; p01 <= '0; p10 <= '0; p11 <= '0;
              end
              default: ;
            endcase
          end else if (in_valid) begin
            meas <= measured_angle;
            dt   <= time_step;
            rate <= kaf_pkg::sat32(66'(gyro_rate) - 66'(bias));
            corrected_rate <= kaf_pkg::sat32(66'(gyro_rate) - 66'(bias));
            step  <= '0;
            state <= kaf_pkg::ST_PRED;
          end
        end
        kaf_pkg::ST_PRED: begin
          // steps 0..7 on the shared multiplier
          step <= step + 4'd1;
          case (step)
            4'd1: ang <= kaf_pkg::sat32(66'(ang) + rounded);
            4'd3: begin
              acc <= rounded - 66'(p01) - 66'(p10)
                     + 66'(signed'({34'd0, (33'(q_angle) + 33'd8) >> 4}));
              p01 <= kaf_pkg::sat32(66'(p01) - rounded);
              p10 <= kaf_pkg::sat32(66'(p10) - rounded);
            end
            4'd5: p00 <= kaf_pkg::sat32(66'(p00) + rounded);
            4'd7: begin
              p11 <= kaf_pkg::sat32(66'(p11) + rounded);
              div_sel <= 1'b0;
              state <= kaf_pkg::ST_COV;
            end
            default: ;
          endcase
        end
        kaf_pkg::ST_COV: begin
          innov <= 33'(meas) - 33'(ang);
          if (s_val <= 0) begin
            k0 <= '0; k1 <= '0;
            step <= 4'd8;
            state <= kaf_pkg::ST_CORR;
          end else begin
            div_start <= 1'b1;
            state <= kaf_pkg::ST_DIV;
          end
        end
        kaf_pkg::ST_DIV: begin
          if (!div_start && !div_busy) begin
            if (!div_sel) begin
              k0 <= gain_of(div_q, num_neg);
              div_sel <= 1'b1;
              div_start <= 1'b1;
            end else begin
              k1 <= gain_of(div_q, num_neg);
              step <= 4'd8;
              state <= kaf_pkg::ST_CORR;
            end
          end
        end
        kaf_pkg::ST_CORR: begin
          step <= step + 4'd1;
          case (step)
            4'd9:  ang  <= kaf_pkg::sat32(66'(ang) + rounded);
            4'd10: bias <= kaf_pkg::sat32(66'(bias) + rounded);
            4'd11: p00  <= kaf_pkg::sat32(66'(p00) - rounded);
            4'd12: p10  <= kaf_pkg::sat32(66'(p10) - rounded);
            4'd13: p01  <= kaf_pkg::sat32(66'(p01) - rounded);
            4'd14: begin
              p11   <= kaf_pkg::sat32(66'(p11) - rounded);
              state <= kaf_pkg::ST_DONE;
            end
            default: ;
          endcase
        end
        kaf_pkg::ST_DONE: begin
          if (!out_stall) begin
            state <= kaf_pkg::ST_IDLE;
          end
        end
        default: state <= kaf_pkg::ST_IDLE;
      endcase
    end
  end

  // Both products on p00 are issued in steps 10 and 11, before p00 is written
  // at the end of step 11; both on p01 in steps 12 and 13, before p01 is
  // written at the end of step 13. All four use the predicted values.

  a_no_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    (state != kaf_pkg::ST_IDLE) |-> !cfg_ready)
    else $error("config accepted while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(filtered_angle)))
    else $error("result dropped under stall");
  a_no_div_in_corr: assert property (@(posedge clk) disable iff (rst)
    (state == kaf_pkg::ST_CORR) |-> !div_busy)
    else $error("divider busy during correction");

endmodule

// File: tb/sv/kaf_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kaf_filter_checker: angle/bias estimate predictor and result comparator
// Watches the config, input and output channels of the angle Kalman filter,
// tracks its own copy of the estimates and covariance, and checks each
// result field by field against the oldest predicted estimate.
// ----------------------------------------------------------------------------
module kaf_filter_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] measured_angle,
  input  logic signed [31:0] gyro_rate,
  input  logic [16:0]        time_step,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] filtered_angle,
  input  logic signed [31:0] corrected_rate,
  input  logic signed [31:0] bias_out,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 mismatches,
  output int                 estimates_waiting
);

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] rate;
    logic signed [31:0] bias;
  } estimate_t;

  logic [31:0]        angle_q;
  logic [31:0]        bias_q;
  logic [31:0]        meas_r;
  logic signed [31:0] angle_est;
  logic signed [31:0] bias_est;
  logic signed [31:0] cov [4];
  estimate_t          estimate_queue [$];

  function automatic logic signed [31:0] clamp32(input wide_t x);
    if (x > wide_t'(32'sh7fffffff)) begin
      return 32'sh7fffffff;
    end else if (x < -wide_t'(64'sh80000000)) begin
      return 32'sh80000000;
    end
    return x[31:0];
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic wide_t round_down(input wide_t x, input int n);
    return (x + (wide_t'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic wide_t noise_q428(input logic [31:0] q);
    wide_t w;
    w = q;
    return (w + 8) >>> 4;
  endfunction

  function automatic logic signed [31:0] kalman_gain(input wide_t num, input wide_t den);
    if (den <= 0) begin
      return '0;
    end
    return clamp32((num <<< 28) / den);
  endfunction

  task automatic reset_filter();
    angle_q   = kaf_pkg::ANGLE_Q_RESET;
    bias_q    = kaf_pkg::BIAS_Q_RESET;
    meas_r    = kaf_pkg::MEAS_R_RESET;
    angle_est = '0;
    bias_est  = '0;
    foreach (cov[i]) cov[i] = '0;
  endtask

  task automatic filter_update(input logic signed [31:0] meas, input logic signed [31:0] gyro,
                               input logic [16:0] dt_in, output estimate_t est);
    wide_t              dt, w_meas, w_gyro, t, inner, s, innov;
    wide_t              p00, p01, p10, p11;
    logic signed [31:0] rate, k0, k1, n00, n01, n10, n11;
    dt     = dt_in;
    w_meas = meas;
    w_gyro = gyro;
    p00 = cov[0];
    p01 = cov[1];
    p10 = cov[2];
    p11 = cov[3];

    // predict
    rate      = clamp32(w_gyro - wide_t'(bias_est));
    angle_est = clamp32(wide_t'(angle_est) + round_down(dt * wide_t'(rate), 16));
    t     = round_down(dt * p11, 16);
    inner = t - p01 - p10 + noise_q428(angle_q);
    n00 = clamp32(p00 + round_down(dt * wide_t'(clamp32(inner)), 16));
    n01 = clamp32(p01 - t);
    n10 = clamp32(p10 - t);
    n11 = clamp32(p11 + ((wide_t'(bias_q) * dt + (wide_t'(1) <<< 19)) >>> 20));

    // gain, skipped when the innovation variance is not positive
    s  = wide_t'(n00) + noise_q428(meas_r);
    k0 = kalman_gain(wide_t'(n00), s);
    k1 = kalman_gain(wide_t'(n10), s);

    // correct
    innov     = w_meas - wide_t'(angle_est);
    angle_est = clamp32(wide_t'(angle_est) + round_down(wide_t'(k0) * innov, 28));
    bias_est  = clamp32(wide_t'(bias_est) + round_down(wide_t'(k1) * innov, 28));
    cov[0] = clamp32(wide_t'(n00) - round_down(wide_t'(k0) * wide_t'(n00), 28));
    cov[1] = clamp32(wide_t'(n01) - round_down(wide_t'(k0) * wide_t'(n01), 28));
    cov[2] = clamp32(wide_t'(n10) - round_down(wide_t'(k1) * wide_t'(n00), 28));
    cov[3] = clamp32(wide_t'(n11) - round_down(wide_t'(k1) * wide_t'(n01), 28));

    est.angle = angle_est;
    est.rate  = rate;
    est.bias  = bias_est;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    estimate_t est;
    if (rst) begin
      reset_filter();
      estimate_queue.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          kaf_pkg::REG_ANGLE_Q: angle_q = cfg_data;
          kaf_pkg::REG_BIAS_Q:  bias_q  = cfg_data;
          kaf_pkg::REG_MEAS_R:  meas_r  = cfg_data;
          kaf_pkg::REG_START_A: begin
            angle_est = cfg_data;
            foreach (cov[i]) cov[i] = '0;
          end
          kaf_pkg::REG_START_B: begin
            bias_est = cfg_data;
            foreach (cov[i]) cov[i] = '0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        filter_update(measured_angle, gyro_rate, time_step, est);
        estimate_queue.push_back(est);
      end
      if (out_valid && !out_stall) begin
        if (estimate_queue.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          mismatches++;
        end else begin
          est = estimate_queue.pop_front();
          if (filtered_angle !== est.angle) report_mismatch("filtered_angle", filtered_angle, est.angle);
          if (corrected_rate !== est.rate) report_mismatch("corrected_rate", corrected_rate, est.rate);
          if (bias_out !== est.bias) report_mismatch("bias_out", bias_out, est.bias);
        end
      end
    end
    estimates_waiting = estimate_queue.size();
  end

endmodule

// File: tb/sv/kalman_angle_filter_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_filter_top_tb: stimulus and verdict for the angle Kalman filter
// Drives directed and random sensor requests under several noise settings
// and idle patterns; a separate checker predicts and compares each result.
// ----------------------------------------------------------------------------
module kalman_angle_filter_top_tb;

  // index outside the register map, must be dropped by the block
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int         HOLD_CYCLES  = 1500;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] measured_angle = '0;
  logic signed [31:0] gyro_rate = '0;
  logic [16:0]        time_step = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] filtered_angle;
  logic signed [31:0] corrected_rate;
  logic signed [31:0] bias_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;

  int  mismatches;
  int  estimates_waiting;
  int  sender_idle_pct = 0;
  int  receiver_idle_pct = 0;
  bit  hold_request = 1'b0;
  bit  hold_active = 1'b0;

  always #5 clk = ~clk;

  kalman_angle_filter_top uut (.*);

  kaf_filter_checker checker_i (.*);

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    out_stall <= hold_active || ($urandom_range(99) < receiver_idle_pct);
  end

  // Long hold-off, counted here so the sender keeps offering requests meanwhile.
  always @(posedge clk) begin
    if (hold_request && !hold_active) begin
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Offer one request; hold it until the block takes it. Leave valid high.
  task automatic send_request(input logic [31:0] angle, input logic [31:0] rate,
                              input logic [16:0] dt);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    measured_angle <= angle;
    gyro_rate      <= rate;
    time_step      <= dt;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted result has been handed off.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (estimates_waiting != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Mostly plausible IMU samples, the rest full-range noise.
  task automatic random_requests(input int count);
    int a, r;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) begin
        a = $urandom_range(32'h0100_0000) - 32'h0080_0000;
        r = $urandom_range(32'h0080_0000) - 32'h0040_0000;
        send_request(a, r, 17'($urandom_range(1, 6554)));
      end else begin
        send_request($urandom, $urandom, 17'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero step, full second and over-range step.
    send_request(32'h0000_0000, 32'h0000_0000, 17'd0);
    send_request(32'h7fff_ffff, 32'h7fff_ffff, 17'd65536);
    send_request(32'h8000_0000, 32'h8000_0000, 17'd65536);
    send_request(32'h7fff_ffff, 32'h8000_0000, 17'h1ffff);
    send_request(32'h8000_0000, 32'h7fff_ffff, 17'h1ffff);
    send_request(32'hffff_ffff, 32'h0000_0001, 17'd1);
    send_request(32'h0005_0000, 32'h0002_0000, 17'd655);
    send_request(32'hfffb_0000, 32'hfffe_0000, 17'd655);
    drain();

    // Zero noise on a cleared covariance: innovation variance is zero, no gain.
    write_reg(kaf_pkg::REG_ANGLE_Q, 32'h0);
    write_reg(kaf_pkg::REG_BIAS_Q, 32'h0);
    write_reg(kaf_pkg::REG_MEAS_R, 32'h0);
    write_reg(kaf_pkg::REG_START_A, 32'h0001_0000);
    write_reg(kaf_pkg::REG_START_B, 32'hffff_8000);
    write_reg(REG_UNMAPPED, 32'hdead_beef);
    send_request(32'h0010_0000, 32'h0001_0000, 17'd6554);
    send_request(32'hfff0_0000, 32'h0000_0000, 17'd65536);
    drain();

    // Maximum noises, start values at the extremes.
    write_reg(kaf_pkg::REG_ANGLE_Q, 32'hffff_ffff);
    write_reg(kaf_pkg::REG_BIAS_Q, 32'hffff_ffff);
    write_reg(kaf_pkg::REG_MEAS_R, 32'hffff_ffff);
    write_reg(kaf_pkg::REG_START_A, 32'h7fff_ffff);
    write_reg(kaf_pkg::REG_START_B, 32'h8000_0000);
    send_request(32'h8000_0000, 32'h7fff_ffff, 17'h1ffff);
    send_request(32'h7fff_ffff, 32'h8000_0000, 17'h1ffff);
    send_request(32'h0000_0000, 32'h0000_0000, 17'd65536);
    drain();

    // Random: sender idles less than receiver; mid-way the receiver holds off.
    write_reg(kaf_pkg::REG_ANGLE_Q, kaf_pkg::ANGLE_Q_RESET);
    write_reg(kaf_pkg::REG_BIAS_Q, kaf_pkg::BIAS_Q_RESET);
    write_reg(kaf_pkg::REG_MEAS_R, kaf_pkg::MEAS_R_RESET);
    write_reg(kaf_pkg::REG_START_A, 32'h0);
    write_reg(kaf_pkg::REG_START_B, 32'h0);
    sender_idle_pct   = 31;
    receiver_idle_pct = 71;
    random_requests(300);
    hold_request = 1'b1;
    random_requests(10);
    hold_request = 1'b0;
    random_requests(300);
    drain();

    // Random with swapped idle rates and small noises.
    write_reg(kaf_pkg::REG_ANGLE_Q, 32'd1);
    write_reg(kaf_pkg::REG_BIAS_Q, 32'd0);
    write_reg(kaf_pkg::REG_MEAS_R, 32'd16);
    write_reg(kaf_pkg::REG_START_A, $urandom);
    sender_idle_pct   = 71;
    receiver_idle_pct = 31;
    random_requests(700);
    drain();

    // Random with no idling at all.
    write_reg(kaf_pkg::REG_ANGLE_Q, $urandom);
    write_reg(kaf_pkg::REG_BIAS_Q, $urandom);
    write_reg(kaf_pkg::REG_MEAS_R, $urandom);
    write_reg(kaf_pkg::REG_START_B, $urandom);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    random_requests(700);
    drain();

    if (mismatches == 0) begin
      $display("kalman_angle_filter_top_tb OK");
    end else begin
      $display("kalman_angle_filter_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #40ms;
    $display("kalman_angle_filter_top_tb NOT OK");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/kaf_pkg.sv
hw/rtl/kaf_div.sv
hw/rtl/kalman_angle_filter_top.sv
tb/sv/kaf_filter_checker.sv
tb/sv/kalman_angle_filter_top_tb.sv
